@@ hw/rtl/cidg_pkg.sv @@
// Shared types and constants of the CAN identifier gateway.
package cidg_pkg;

   localparam int TrackerSlots = 10;
   localparam int WindowSize   = 10;
   localparam int SlotW        = $clog2(TrackerSlots);
   localparam int AddrW        = 5;

   localparam logic [2:0] RegBaseCanId  = 3'd0;
   localparam logic [2:0] RegDataIdBase = 3'd1;
   localparam logic [2:0] RegFastPeriod = 3'd2;
   localparam logic [2:0] RegSlowPeriod = 3'd3;
   localparam logic [2:0] RegSlowLow    = 3'd4;
   localparam logic [2:0] RegSlowHigh   = 3'd5;
   localparam logic [2:0] RegWideOffset = 3'd6;

   localparam logic OpTick    = 1'b0;
   localparam logic OpMessage = 1'b1;

   typedef logic [SlotW-1:0] slot_idx_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] time_ms;
      logic [10:0] can_id;
      logic [6:0]  msg_len;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  byte4;
      logic [7:0]  byte5;
   } req_type;

   typedef struct packed {
      logic [7:0] data_id;
      logic [2:0] frame_length;
      logic [7:0] out0;
      logic [7:0] out1;
      logic [7:0] out2;
      logic [7:0] out3;
      logic [7:0] out4;
      logic [7:0] out5;
      logic [7:0] checksum;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [10:0] base_can_id;
      logic [7:0]  data_id_base;
      logic [15:0] fast_period_ms;
      logic [15:0] slow_period_ms;
      logic [3:0]  slow_offset_low;
      logic [3:0]  slow_offset_high;
      logic [3:0]  wide_offset;
   } cfg_type;

   // one tracker entry as held in the slot memory
   typedef struct packed {
      logic [10:0] id;
      logic [6:0]  length;
      logic [47:0] bytes;
      logic [31:0] last_sent;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [SlotW-1:0]  wr_addr;
      entry_type         wr_data;
      logic [SlotW-1:0]  rd_addr;
   } mem_ctl_type;

endpackage

@@ hw/rtl/cidg_slot_mem.sv @@
// Tracker slot memory: one write port, one registered read port.
module cidg_slot_mem (
   input  logic                   clock,
   input  cidg_pkg::mem_ctl_type  ctl,
   output cidg_pkg::entry_type    rd_data
);
   cidg_pkg::entry_type mem [cidg_pkg::TrackerSlots];
   cidg_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/cidg_csr.sv @@
// Configuration register file behind the APB-style port.
module cidg_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cidg_pkg::AddrW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output cidg_pkg::cfg_type           cfg
);
   cidg_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr;
   logic [2:0]        idx;

   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            cidg_pkg::RegBaseCanId:  cfg_in.base_can_id      = csr_pwdata[10:0];
            cidg_pkg::RegDataIdBase: cfg_in.data_id_base     = csr_pwdata[7:0];
            cidg_pkg::RegFastPeriod: cfg_in.fast_period_ms   = csr_pwdata[15:0];
            cidg_pkg::RegSlowPeriod: cfg_in.slow_period_ms   = csr_pwdata[15:0];
            cidg_pkg::RegSlowLow:    cfg_in.slow_offset_low  = csr_pwdata[3:0];
            cidg_pkg::RegSlowHigh:   cfg_in.slow_offset_high = csr_pwdata[3:0];
            cidg_pkg::RegWideOffset: cfg_in.wide_offset      = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (idx)
         cidg_pkg::RegBaseCanId:  csr_prdata[10:0] = cfg_ff.base_can_id;
         cidg_pkg::RegDataIdBase: csr_prdata[7:0]  = cfg_ff.data_id_base;
         cidg_pkg::RegFastPeriod: csr_prdata[15:0] = cfg_ff.fast_period_ms;
         cidg_pkg::RegSlowPeriod: csr_prdata[15:0] = cfg_ff.slow_period_ms;
         cidg_pkg::RegSlowLow:    csr_prdata[3:0]  = cfg_ff.slow_offset_low;
         cidg_pkg::RegSlowHigh:   csr_prdata[3:0]  = cfg_ff.slow_offset_high;
         cidg_pkg::RegWideOffset: csr_prdata[3:0]  = cfg_ff.wide_offset;
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_can_id      <= 11'd256;
         cfg_ff.data_id_base     <= 8'd1;
         cfg_ff.fast_period_ms   <= 16'd100;
         cfg_ff.slow_period_ms   <= 16'd1000;
         cfg_ff.slow_offset_low  <= 4'd7;
         cfg_ff.slow_offset_high <= 4'd8;
         cfg_ff.wide_offset      <= 4'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

@@ hw/rtl/cidg_engine.sv @@
// Sequencer: slot match, message update and slot scan over the slot memory.
module cidg_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  cidg_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cidg_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cidg_pkg::rsp_type      rsp_data,
   output cidg_pkg::mem_ctl_type  mem_ctl,
   input  cidg_pkg::entry_type    rd_data
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_EVAL  = 5'b00100,
      ST_WAIT  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type                         state_ff, state_in;
   logic [cidg_pkg::TrackerSlots-1:0] valid_ff, valid_in;
   cidg_pkg::slot_idx_type            idx_ff, idx_in;
   cidg_pkg::req_type                 item_ff, item_in;
   logic                              hit_ff, hit_in;
   cidg_pkg::slot_idx_type            tgt_ff, tgt_in;
   logic                              pend_ff, pend_in;   // frame held back for last flag
   cidg_pkg::rsp_type                 held_ff, held_in;
   logic                              ov_ff, ov_in;
   cidg_pkg::rsp_type                 out_ff, out_in;

   logic                              is_last;
   logic                              win_ok, in_win_msg;
   logic [11:0]                       diff_msg, diff_slot;
   logic                              hit_now;
   cidg_pkg::entry_type               ent;
   logic [3:0]                        offs;
   logic [15:0]                       period;
   logic [31:0]                       elapsed;
   logic                              wide, send;
   logic [7:0]                        did, sum;
   cidg_pkg::rsp_type                 frame;
   logic                              accept;
   logic                              upd;

   assign is_last  = (idx_ff == cidg_pkg::slot_idx_type'(cidg_pkg::TrackerSlots - 1));
   assign diff_msg = {1'b0, item_ff.can_id} - {1'b0, cfg.base_can_id};
   assign in_win_msg = (item_ff.operation == cidg_pkg::OpMessage) && !diff_msg[11]
                       && (diff_msg[10:0] < 11'(cidg_pkg::WindowSize));
   assign accept = req_valid && !req_stall;

   // the message for this slot modifies the entry as it passes through
   assign upd = in_win_msg && hit_ff && (tgt_ff == idx_ff);

   always_comb begin
      ent = rd_data;
      if (upd) begin
         if (!valid_ff[idx_ff] || rd_data.id != item_ff.can_id) begin
            ent.last_sent = '0;
         end
         ent.id     = item_ff.can_id;
         ent.length = item_ff.msg_len;
         ent.bytes  = {item_ff.byte5, item_ff.byte4, item_ff.byte3,
                       item_ff.byte2, item_ff.byte1, item_ff.byte0};
      end
   end

   assign diff_slot = {1'b0, ent.id} - {1'b0, cfg.base_can_id};
   assign win_ok    = !diff_slot[11] && (diff_slot[10:0] < 11'(cidg_pkg::WindowSize));
   assign offs      = diff_slot[3:0];
   assign period    = (offs >= cfg.slow_offset_low && offs <= cfg.slow_offset_high)
                      ? cfg.slow_period_ms : cfg.fast_period_ms;
   assign elapsed   = item_ff.time_ms - ent.last_sent;
   assign wide      = (offs == cfg.wide_offset);
   assign send      = (valid_ff[idx_ff] || upd) && win_ok && (elapsed >= {16'd0, period})
                      && (wide ? (ent.length >= 7'd6) : (ent.length >= 7'd1));
   assign did       = cfg.data_id_base + {4'd0, offs};

   always_comb begin
      frame = '0;
      frame.data_id      = did;
      frame.frame_length = wide ? 3'd6 : 3'd1;
      frame.out0         = ent.bytes[7:0];
      if (wide) begin
         frame.out1 = ent.bytes[15:8];
         frame.out2 = ent.bytes[23:16];
         frame.out3 = ent.bytes[31:24];
         frame.out4 = ent.bytes[39:32];
         frame.out5 = ent.bytes[47:40];
      end
      sum = did + {5'd0, frame.frame_length} + frame.out0 + frame.out1 + frame.out2
            + frame.out3 + frame.out4 + frame.out5;
      frame.checksum = sum;
      frame.last     = 1'b0;
   end

   // match search runs during the read pass: id hit beats first free slot
   assign hit_now   = valid_ff[idx_ff] && rd_data.id == item_ff.can_id;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      item_in  = item_ff;
      hit_in   = hit_ff;
      tgt_in   = tgt_ff;
      pend_in  = pend_ff;
      held_in  = held_ff;
      ov_in    = ov_ff;
      out_in   = out_ff;
      mem_ctl  = '0;
      mem_ctl.rd_addr = idx_ff;
      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               idx_in   = '0;
               hit_in   = 1'b0;
               tgt_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // first pass: locate the slot; read data arrives in the cycle after its address
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!hit_ff) begin
               if (hit_now) begin
                  hit_in = 1'b1;
                  tgt_in = idx_ff;
               end
            end
            if (is_last || (hit_in && hit_now)) begin
               // search done; choose free slot when no hit
               if (!hit_in) begin
                  for (int i = cidg_pkg::TrackerSlots - 1; i >= 0; i--) begin
                     if (!valid_ff[i]) begin
                        hit_in = 1'b1;
                        tgt_in = cidg_pkg::slot_idx_type'(i);
                     end
                  end
               end
               idx_in   = '0;
               state_in = ST_WAIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_WAIT: begin
            // scan pass: read issued, evaluate next cycle in ST_FLUSH
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!ov_ff || !rsp_stall) begin
               if (upd) begin
                  valid_in[idx_ff] = 1'b1;
               end
               if (send || upd) begin
                  mem_ctl.wr_en   = 1'b1;
                  mem_ctl.wr_addr = idx_ff;
                  mem_ctl.wr_data = ent;
                  if (send) begin
                     mem_ctl.wr_data.last_sent = item_ff.time_ms;
                  end
               end
               if (send) begin
                  if (pend_ff) begin
                     out_in = held_ff;
                     ov_in  = 1'b1;
                  end
                  held_in = frame;
                  pend_in = 1'b1;
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_WAIT;
               end
               mem_ctl.rd_addr = idx_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // final pending frame goes out once the scan is over
      if (state_ff == ST_IDLE && pend_ff && !ov_in) begin
         out_in      = held_ff;
         out_in.last = 1'b1;
         ov_in       = 1'b1;
         pend_in     = 1'b0;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || pend_ff;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
         idx_ff   <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
         idx_ff   <= idx_in;
         hit_ff   <= hit_in;
      end
      item_ff <= item_in;
      tgt_ff  <= tgt_in;
      held_ff <= held_in;
      out_ff  <= out_in;
   end
endmodule

@@ hw/rtl/can_id_gateway_rate_limited_top.sv @@
// Top level of the rate-limited CAN identifier gateway.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  cidg_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  cidg_pkg::rsp_type
//   csr      in         APB psel/penable     7 registers, 32-bit data
//
// An item holds the input through a match pass and a scan pass; each visits a
// slot in a read state and then an evaluate state (ST_READ, ST_EVAL; ST_WAIT,
// ST_FLUSH) since the slot memory read is registered; the match pass ends early
// on a hit, and the final frame is handed out after the scan.
// Reset is synchronous; slot valid bits clear at once, memory needs no sweep
// since last_sent is cleared when a slot is claimed.
// A full, stalled result register holds the scan; the input stalls until the
// scan and its final frame are done.
module can_id_gateway_rate_limited_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  cidg_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cidg_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cidg_pkg::AddrW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   cidg_pkg::cfg_type     cfg;
   cidg_pkg::mem_ctl_type mem_ctl;
   cidg_pkg::entry_type   rd_data;

   assign csr_pready = 1'b1;

   cidg_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .cfg
   );

   cidg_slot_mem u_mem (
      .clock, .ctl(mem_ctl), .rd_data
   );

   cidg_engine u_eng (
      .clock, .reset, .cfg, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .mem_ctl, .rd_data
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");
   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.frame_length == 3'd1 || rsp_data.frame_length == 3'd6))
      else $error("bad frame length");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !mem_ctl.wr_en)
      else $error("slot write while idle");
endmodule

@@ tb/can_id_gateway_rate_limited_top_tb.sv @@
// Testbench for the rate-limited CAN identifier gateway against a behavioral predictor.
`timescale 1ns / 100ps

module can_id_gateway_rate_limited_top_tb;

   class frame_scoreboard;
      cidg_pkg::cfg_type cfg;
      logic        trk_valid [cidg_pkg::TrackerSlots];
      logic [10:0] trk_id    [cidg_pkg::TrackerSlots];
      logic [6:0]  trk_len   [cidg_pkg::TrackerSlots];
      logic [7:0]  trk_bytes [cidg_pkg::TrackerSlots][6];
      logic [31:0] trk_sent  [cidg_pkg::TrackerSlots];
      cidg_pkg::rsp_type pending_frames[$];
      int          mismatches;

      function new();
         cfg = '{11'd256, 8'd1, 16'd100, 16'd1000, 4'd7, 4'd8, 4'd3};
         mismatches = 0;
         foreach (trk_valid[i]) begin
            trk_valid[i] = 1'b0;
            trk_sent[i] = '0;
         end
      endfunction

      function bit window_offset(logic [10:0] id, output int unsigned ofs);
         ofs = 0;
         if (id < cfg.base_can_id || id - cfg.base_can_id >= cidg_pkg::WindowSize) return 0;
         ofs = id - cfg.base_can_id;
         return 1;
      endfunction

      function void note_request(cidg_pkg::req_type r);
         int unsigned ofs, period, flen;
         int          slot, n;
         logic [7:0]  sum, b;
         cidg_pkg::rsp_type f;
         cidg_pkg::rsp_type frames[$];
         slot = -1;
         if (r.operation == cidg_pkg::OpMessage && window_offset(r.can_id, ofs)) begin
            for (int i = 0; i < cidg_pkg::TrackerSlots; i++)
               if (slot < 0 && trk_valid[i] && trk_id[i] == r.can_id) slot = i;
            for (int i = 0; i < cidg_pkg::TrackerSlots; i++)
               if (slot < 0 && !trk_valid[i]) begin
                  slot = i;
                  trk_valid[i] = 1'b1;
                  trk_id[i] = r.can_id;
                  trk_sent[i] = '0;
               end
            if (slot >= 0) begin
               trk_len[slot] = r.msg_len;
               trk_bytes[slot] = '{r.byte0, r.byte1, r.byte2, r.byte3, r.byte4, r.byte5};
            end
         end
         for (int i = 0; i < cidg_pkg::TrackerSlots; i++) begin
            if (!trk_valid[i] || !window_offset(trk_id[i], ofs)) continue;
            period = (ofs >= cfg.slow_offset_low && ofs <= cfg.slow_offset_high)
                     ? cfg.slow_period_ms : cfg.fast_period_ms;
            if (r.time_ms - trk_sent[i] < period) continue;
            flen = (ofs == cfg.wide_offset) ? 6 : 1;
            if (trk_len[i] < flen) continue;
            f = '0;
            f.data_id = 8'(cfg.data_id_base + ofs);
            f.frame_length = 3'(flen);
            sum = 8'(f.data_id + flen);
            for (int j = 0; j < 6; j++) begin
               b = (j < flen) ? trk_bytes[i][j] : 8'd0;
               sum += b;
               case (j)
                  0: f.out0 = b;
                  1: f.out1 = b;
                  2: f.out2 = b;
                  3: f.out3 = b;
                  4: f.out4 = b;
                  default: f.out5 = b;
               endcase
            end
            f.checksum = sum;
            trk_sent[i] = r.time_ms;
            frames.push_back(f);
         end
         n = frames.size();
         if (n > 0) frames[n-1].last = 1'b1;
         foreach (frames[k]) pending_frames.push_back(frames[k]);
      endfunction

      function void check_frame(cidg_pkg::rsp_type got);
         cidg_pkg::rsp_type exp_f;
         if (pending_frames.size() == 0) begin
            report(got, '0, "unexpected frame");
            return;
         end
         exp_f = pending_frames.pop_front();
         if (got !== exp_f) report(got, exp_f, "frame mismatch");
      endfunction

      function void report(cidg_pkg::rsp_type got, cidg_pkg::rsp_type exp_f, string what);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s: exp id %h len %0d b %h %h %h %h %h %h ck %h last %b",
                     $realtime, what, exp_f.data_id, exp_f.frame_length, exp_f.out0,
                     exp_f.out1, exp_f.out2, exp_f.out3, exp_f.out4, exp_f.out5,
                     exp_f.checksum, exp_f.last);
         if (mismatches <= 10)
            $display("   got id %h len %0d b %h %h %h %h %h %h ck %h last %b",
                     got.data_id, got.frame_length, got.out0, got.out1, got.out2,
                     got.out3, got.out4, got.out5, got.checksum, got.last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cidg_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cidg_pkg::rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [cidg_pkg::AddrW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frame_scoreboard board = new();
   bit          send_gaps = 1'b1;
   bit          rx_gaps = 1'b1;
   bit          hold_off = 1'b0;
   int          idle_cycles = 0;
   logic [31:0] now_ms = 32'd0;

   can_id_gateway_rate_limited_top i_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (req_valid && !req_stall) board.note_request(req_data);
      if (rsp_valid && !rsp_stall) board.check_frame(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles > 20000) begin
         $display("can_id_gateway_rate_limited_top test failed");
         $finish;
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (1500) @(negedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= cidg_pkg::AddrW'(4 * idx);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         cidg_pkg::RegBaseCanId:  board.cfg.base_can_id = value[10:0];
         cidg_pkg::RegDataIdBase: board.cfg.data_id_base = value[7:0];
         cidg_pkg::RegFastPeriod: board.cfg.fast_period_ms = value[15:0];
         cidg_pkg::RegSlowPeriod: board.cfg.slow_period_ms = value[15:0];
         cidg_pkg::RegSlowLow:    board.cfg.slow_offset_low = value[3:0];
         cidg_pkg::RegSlowHigh:   board.cfg.slow_offset_high = value[3:0];
         cidg_pkg::RegWideOffset: board.cfg.wide_offset = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // valid stays up after a transfer until the next item, an idle gap or drain replaces it
   task automatic send(cidg_pkg::req_type r);
      int n;
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (board.pending_frames.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   function automatic cidg_pkg::req_type make_item(bit msg, logic [10:0] id, logic [6:0] len);
      cidg_pkg::req_type r;
      r.operation = msg;
      r.time_ms = now_ms;
      r.can_id = id;
      r.msg_len = len;
      r = {r.operation, r.time_ms, r.can_id, r.msg_len, 48'({$urandom, $urandom})};
      return r;
   endfunction

   // mostly in-window ids with some noise; time advances by varied steps
   task automatic random_items(int count, bit small_steps);
      cidg_pkg::req_type r;
      logic [10:0] id;
      int          pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 7)
            id = 11'(board.cfg.base_can_id + $urandom_range(0, cidg_pkg::WindowSize + 1));
         else
            id = 11'($urandom_range(0, 2047));
         now_ms += small_steps ? $urandom_range(0, 150) :
                   ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1200));
         pick = $urandom_range(0, 3);
         r = make_item($urandom_range(0, 3) != 0, id,
                       pick == 0 ? 7'($urandom_range(0, 6)) :
                       pick == 1 ? 7'd64 : 7'($urandom_range(0, 127)));
         send(r);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, short messages, wide offset, wrap of time
      now_ms = 32'd100;
      for (int o = 0; o < cidg_pkg::WindowSize; o++)
         send(make_item(cidg_pkg::OpMessage, 11'(256 + o), 7'(o)));
      send(make_item(cidg_pkg::OpMessage, 11'd255, 7'd8));
      send(make_item(cidg_pkg::OpMessage, 11'd266, 7'd8));
      now_ms = 32'd1200;
      send(make_item(cidg_pkg::OpTick, 11'h7FF, 7'd127));
      send(make_item(cidg_pkg::OpMessage, 11'd259, 7'd6));
      send(make_item(cidg_pkg::OpMessage, 11'd256, 7'd0));
      now_ms = 32'hFFFF_FFF0;
      send(make_item(cidg_pkg::OpMessage, 11'd257, 7'd64));
      now_ms = 32'h0000_0060;
      send(make_item(cidg_pkg::OpTick, 11'd0, 7'd0));
      send('1);
      send('0);
      drain();

      write_reg(cidg_pkg::RegFastPeriod, 32'd0);
      write_reg(cidg_pkg::RegSlowPeriod, 32'hFFFF);
      write_reg(cidg_pkg::RegWideOffset, 32'd15);
      random_items(80, 1'b1);
      drain();

      write_reg(cidg_pkg::RegBaseCanId, 32'h7FA);
      write_reg(cidg_pkg::RegDataIdBase, 32'hFF);
      write_reg(cidg_pkg::RegSlowLow, 32'd9);
      write_reg(cidg_pkg::RegSlowHigh, 32'd2);
      write_reg(cidg_pkg::RegWideOffset, 32'd0);
      write_reg(3'd7, 32'h1234);
      random_items(80, 1'b0);
      drain();

      write_reg(cidg_pkg::RegBaseCanId, 32'd0);
      write_reg(cidg_pkg::RegDataIdBase, 32'h80);
      write_reg(cidg_pkg::RegFastPeriod, 32'd5);
      write_reg(cidg_pkg::RegSlowPeriod, 32'd0);
      write_reg(cidg_pkg::RegSlowLow, 32'd0);
      write_reg(cidg_pkg::RegSlowHigh, 32'd15);
      write_reg(cidg_pkg::RegWideOffset, 32'd9);
      hold_off = 1'b1;
      random_items(80, 1'b1);
      drain();

      write_reg(cidg_pkg::RegBaseCanId, 32'd256);
      write_reg(cidg_pkg::RegDataIdBase, 32'd1);
      write_reg(cidg_pkg::RegFastPeriod, 32'd100);
      write_reg(cidg_pkg::RegSlowPeriod, 32'd1000);
      write_reg(cidg_pkg::RegSlowLow, 32'd7);
      write_reg(cidg_pkg::RegSlowHigh, 32'd8);
      write_reg(cidg_pkg::RegWideOffset, 32'd3);
      random_items(100, 1'b1);
      send_gaps = 1'b0;
      rx_gaps = 1'b0;
      random_items(60, 1'b1);
      drain();

      if (board.mismatches == 0 && board.pending_frames.size() == 0)
         $display("can_id_gateway_rate_limited_top test passed");
      else
         $display("can_id_gateway_rate_limited_top test failed");
      $finish;
   end
endmodule
